// File: hdl/tdmx_pkg.sv
// Package for the timed task dispatcher: request and result types, function
// and status codes, fixed field widths. No dependencies.
package tdmx_pkg;

  localparam int unsigned IdBits  = 18;
  localparam int unsigned MutBits = 4;
  localparam int unsigned EntBits = IdBits + MutBits;
  localparam int unsigned WakeBits = 28;

  localparam logic [WakeBits-1:0] MaxWait = 28'hFFF_FFFF;

  localparam logic [2:0] FnInsert   = 3'd0;
  localparam logic [2:0] FnDispatch = 3'd1;
  localparam logic [2:0] FnFinish   = 3'd2;
  localparam logic [2:0] FnLock     = 3'd3;
  localparam logic [2:0] FnUnlock   = 3'd4;
  localparam logic [2:0] FnDrop     = 3'd5;
  localparam logic [2:0] FnRetime   = 3'd6;

  localparam logic [1:0] StsOk      = 2'd0;
  localparam logic [1:0] StsReject  = 2'd1;
  localparam logic [1:0] StsIdle    = 2'd2;
  localparam logic [1:0] StsNoMatch = 2'd3;

  typedef struct packed {
    logic [2:0]         func;
    logic [IdBits-1:0]  task_id;
    logic [31:0]        task_arg;
    logic [31:0]        due_time;
    logic [31:0]        now;
    logic [MutBits-1:0] mtx_bits;
    logic [4:0]         slot;
    logic               keep;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [4:0]          out_slot;
    logic [IdBits-1:0]   out_task;
    logic [31:0]         out_arg;
    logic [WakeBits-1:0] wake_delay;
    logic                already_set;
  } rsp_t;

endpackage

// File: hdl/tdmx_table.sv
// Slot table: link, task/mutex, argument and due memories with one
// registered read port. Uses tdmx_pkg.
module tdmx_table #(
  parameter int unsigned SLOTS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [$clog2(SLOTS)-1:0]           raddr_i,
  input  logic                               link_we_i,
  input  logic [$clog2(SLOTS)-1:0]           link_wa_i,
  input  logic [$clog2(SLOTS+1)-1:0]         link_wd_i,
  input  logic [$clog2(SLOTS)-1:0]           ent_wa_i,
  input  logic                               task_we_i,
  input  logic [tdmx_pkg::EntBits-1:0]       task_wd_i,
  input  logic                               arg_we_i,
  input  logic [31:0]                        arg_wd_i,
  input  logic                               due_we_i,
  input  logic [31:0]                        due_wd_i,
  output logic [$clog2(SLOTS+1)-1:0]         rd_link_o,
  output logic [tdmx_pkg::EntBits-1:0]       rd_task_o,
  output logic [31:0]                        rd_arg_o,
  output logic [31:0]                        rd_due_o
);
  import tdmx_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned LW = $clog2(SLOTS+1);

  logic [LW-1:0]      link_mem [SLOTS];
  logic [EntBits-1:0] task_mem [SLOTS];
  logic [31:0]        arg_mem  [SLOTS];
  logic [31:0]        due_mem  [SLOTS];
  logic [SLOTS-1:0]   link_vld_q, task_vld_q;

  logic [IW-1:0]      ra_q;
  logic [LW-1:0]      lk_q;
  logic [EntBits-1:0] tk_q;
  logic               lv_q, tv_q;

  always_ff @(posedge clk_i) begin
    if (link_we_i) link_mem[link_wa_i] <= link_wd_i;
    if (task_we_i) task_mem[ent_wa_i] <= task_wd_i;
    if (arg_we_i)  arg_mem[ent_wa_i]  <= arg_wd_i;
    if (due_we_i)  due_mem[ent_wa_i]  <= due_wd_i;
    lk_q     <= link_mem[raddr_i];
    tk_q     <= task_mem[raddr_i];
    rd_arg_o <= arg_mem[raddr_i];
    rd_due_o <= due_mem[raddr_i];
  end

  // valid bits stand in for the reset contents of link and task memories
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q <= '0;
      task_vld_q <= '0;
      ra_q       <= '0;
      lv_q       <= 1'b0;
      tv_q       <= 1'b0;
    end else begin
      if (link_we_i) link_vld_q[link_wa_i] <= 1'b1;
      if (task_we_i) task_vld_q[ent_wa_i]  <= 1'b1;
      ra_q <= raddr_i;
      lv_q <= link_vld_q[raddr_i];
      tv_q <= task_vld_q[raddr_i];
    end
  end

  assign rd_link_o = lv_q ? lk_q : LW'(ra_q) + LW'(1);
  assign rd_task_o = tv_q ? tk_q : '0;

endmodule

// File: hdl/timed_task_dispatcher_with_mutex_mask_top.sv
// Timed task dispatcher top level: request sequencer and result register
// around the slot table. Uses tdmx_pkg and tdmx_table.

// Holds up to SLOTS-2 tasks in a linked table (slot 0 is a fixed head) and
// serves one request at a time over a valid/ready pair. Dispatch walks the
// list one slot per cycle through the single table read port. Finish that
// frees, and drop, walk the list from the head to find the predecessor and
// then relink in four steps (StUl2 to StUl5). Results sit in an output
// register; a new request is taken once the previous result has been loaded
// there.
module timed_task_dispatcher_with_mutex_mask_top #(
  parameter int unsigned SLOTS   = 32,
  parameter int unsigned MUTEXES = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tdmx_pkg::req_t  in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tdmx_pkg::rsp_t  out_rsp_o
);
  import tdmx_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned LW = $clog2(SLOTS+1);
  localparam logic [MutBits-1:0] MutUsed =
    MutBits'(((1 << MUTEXES) - 1) & ((1 << MutBits) - 1));

  typedef enum logic [3:0] {
    StIdle, StStart, StIns, StDspLink, StDspEval, StDspEnd, StFin, StChk,
    StFp, StUl2, StUl3, StUl4, StUl5, StDone
  } state_e;

  state_e              state_q;
  req_t                req_q;
  rsp_t                res_q, out_q;
  logic                out_v_q;
  logic [IW-1:0]       free_head_q, scan_prev_q, run_q, cur_q, prv_q;
  logic                run_v_q;
  logic [MutBits-1:0]  locked_q;
  logic [WakeBits-1:0] lw_q;
  logic [LW-1:0]       cnt_q;

  // table port
  logic [IW-1:0]      raddr, link_wa, ent_wa;
  logic               link_we, task_we, arg_we, due_we;
  logic [LW-1:0]      link_wd, rd_link;
  logic [EntBits-1:0] task_wd, rd_task;
  logic [31:0]        due_wd, rd_arg, rd_due;

  tdmx_table #(.SLOTS(SLOTS)) u_table (
    .clk_i, .rst_ni,
    .raddr_i(raddr),
    .link_we_i(link_we), .link_wa_i(link_wa), .link_wd_i(link_wd),
    .ent_wa_i(ent_wa),
    .task_we_i(task_we), .task_wd_i(task_wd),
    .arg_we_i(arg_we),   .arg_wd_i(req_q.task_arg),
    .due_we_i(due_we),   .due_wd_i(due_wd),
    .rd_link_o(rd_link), .rd_task_o(rd_task),
    .rd_arg_o(rd_arg),   .rd_due_o(rd_due)
  );

  // shared decode of the word just read
  logic [MutBits-1:0] mm;
  logic [IW-1:0]      slot_idx, link_idx;
  logic [31:0]        dlt;
  logic               link_end, is_due, unlocked, cnt_last, ins_ok, match, fin_keep;
  logic               lw_less, hit_k;

  assign mm       = req_q.mtx_bits & MutUsed;
  assign slot_idx = IW'({{IW{1'b0}}, req_q.slot});
  assign link_idx = IW'(rd_link);
  assign link_end = rd_link >= LW'(SLOTS);
  assign dlt      = rd_due - req_q.now;
  assign is_due   = (dlt == 32'd0) || dlt[31];
  assign lw_less  = dlt < {4'd0, lw_q};
  assign unlocked = (rd_task[EntBits-1:IdBits] & locked_q) == '0;
  assign cnt_last = (cnt_q + LW'(1)) == LW'(SLOTS);
  assign ins_ok   = (req_q.task_id != '0) && !link_end;
  assign match    = (rd_task != '0) && (rd_task[IdBits-1:0] == req_q.task_id) &&
                    (rd_arg == req_q.task_arg);
  assign fin_keep = req_q.keep || !dlt[31];
  assign hit_k    = rd_link == LW'(cur_q);

  always_comb begin
    raddr   = '0;
    link_we = 1'b0;
    link_wa = prv_q;
    link_wd = rd_link;
    ent_wa  = cur_q;
    task_we = 1'b0;
    task_wd = '0;
    arg_we  = 1'b0;
    due_we  = 1'b0;
    due_wd  = req_q.due_time;
    unique case (state_q)
      StStart: begin
        case (req_q.func)
          FnInsert:         raddr = free_head_q;
          FnDispatch:       raddr = scan_prev_q;
          FnFinish:         raddr = run_q;
          FnDrop, FnRetime: raddr = slot_idx;
          default:          raddr = '0;
        endcase
      end
      StIns: begin
        if (ins_ok) begin
          ent_wa  = free_head_q;
          task_we = 1'b1;
          task_wd = {mm, req_q.task_id};
          arg_we  = 1'b1;
          due_we  = 1'b1;
        end
      end
      StDspLink, StDspEval: raddr = link_idx;
      StFin: begin
        if (fin_keep && dlt[31]) begin
          due_we = 1'b1;
          due_wd = req_q.now;
        end
      end
      StChk: due_we = match && (req_q.func == FnRetime);
      StFp:  raddr = hit_k ? cur_q : link_idx;
      StUl2: link_we = 1'b1;
      StUl3: raddr = free_head_q;
      StUl4: begin
        link_we = 1'b1;
        link_wa = cur_q;
      end
      StUl5: begin
        link_we = 1'b1;
        link_wa = free_head_q;
        link_wd = LW'(cur_q);
        task_we = 1'b1;
      end
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      req_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_v_q     <= 1'b0;
      free_head_q <= IW'(1);
      scan_prev_q <= '0;
      run_q       <= '0;
      run_v_q     <= 1'b0;
      cur_q       <= '0;
      prv_q       <= '0;
      locked_q    <= '0;
      lw_q        <= MaxWait;
      cnt_q       <= '0;
    end else begin
      if (state_q == StDone && (!out_v_q || out_ready_i)) out_v_q <= 1'b1;
      else if (out_ready_i)                                out_v_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            req_q   <= in_req_i;
            res_q   <= '0;
            cnt_q   <= '0;
            prv_q   <= '0;
            state_q <= StStart;
          end
        end
        StStart: begin
          case (req_q.func)
            FnInsert: state_q <= StIns;
            FnDispatch: begin
              if (run_v_q) begin
                res_q.status <= StsReject;
                state_q      <= StDone;
              end else begin
                prv_q   <= scan_prev_q;
                state_q <= StDspLink;
              end
            end
            FnFinish: begin
              if (!run_v_q) begin
                res_q.status <= StsNoMatch;
                state_q      <= StDone;
              end else begin
                cur_q   <= run_q;
                state_q <= StFin;
              end
            end
            FnLock: begin
              locked_q <= (locked_q | mm) & MutUsed;
              res_q.already_set <= ((locked_q | mm) & MutUsed) == locked_q;
              state_q <= StDone;
            end
            FnUnlock: begin
              locked_q <= locked_q & ~mm & MutUsed;
              res_q.already_set <= (locked_q & ~mm & MutUsed) == locked_q;
              state_q <= StDone;
            end
            FnDrop, FnRetime: begin
              if (int'(req_q.slot) >= int'(SLOTS)) begin
                res_q.status <= StsNoMatch;
                state_q      <= StDone;
              end else begin
                cur_q   <= slot_idx;
                state_q <= StChk;
              end
            end
            default: begin
              res_q.status <= StsReject;
              state_q      <= StDone;
            end
          endcase
        end
        StIns: begin
          if (ins_ok) begin
            free_head_q    <= link_idx;
            res_q.out_slot <= 5'({5'd0, free_head_q});
          end else begin
            res_q.status <= StsReject;
          end
          state_q <= StDone;
        end
        StDspLink: begin
          cur_q   <= link_idx;
          state_q <= link_end ? StDspEnd : StDspEval;
        end
        StDspEval: begin
          if (rd_task == '0) begin
            state_q <= StDspEnd;
          end else if (unlocked && is_due) begin
            run_v_q        <= 1'b1;
            run_q          <= cur_q;
            scan_prev_q    <= prv_q;
            res_q.out_slot <= 5'({5'd0, cur_q});
            res_q.out_task <= rd_task[IdBits-1:0];
            res_q.out_arg  <= rd_arg;
            state_q        <= StDone;
          end else begin
            if (unlocked && lw_less) lw_q <= dlt[WakeBits-1:0];
            cnt_q <= cnt_q + LW'(1);
            prv_q <= cur_q;
            cur_q <= link_idx;
            if (cnt_last || link_end) state_q <= StDspEnd;
          end
        end
        StDspEnd: begin
          res_q.status     <= StsIdle;
          res_q.wake_delay <= lw_q;
          scan_prev_q      <= '0;
          lw_q             <= MaxWait;
          state_q          <= StDone;
        end
        StFin: begin
          run_v_q        <= 1'b0;
          res_q.out_slot <= 5'({5'd0, cur_q});
          if (fin_keep) begin
            if (dlt[31])      lw_q <= '0;
            else if (lw_less) lw_q <= dlt[WakeBits-1:0];
            scan_prev_q <= cur_q;
            state_q     <= StDone;
          end else begin
            state_q <= StFp;
          end
        end
        StChk: begin
          if (!match) begin
            res_q.status <= StsNoMatch;
            state_q      <= StDone;
          end else if (req_q.func == FnRetime) begin
            res_q.out_slot <= 5'({5'd0, cur_q});
            state_q        <= StDone;
          end else if (run_v_q && (run_q == cur_q)) begin
            res_q.status <= StsReject;
            state_q      <= StDone;
          end else begin
            state_q <= StFp;
          end
        end
        StFp: begin
          // predecessor search from the head, one link per cycle
          if (hit_k) begin
            state_q <= StUl2;
          end else if (link_end || cnt_last) begin
            if (req_q.func == FnFinish) scan_prev_q <= '0;
            else                        res_q.status <= StsNoMatch;
            state_q <= StDone;
          end else begin
            cnt_q <= cnt_q + LW'(1);
            prv_q <= link_idx;
          end
        end
        StUl2: state_q <= StUl3;
        StUl3: state_q <= StUl4;
        StUl4: state_q <= StUl5;
        StUl5: begin
          if (req_q.func == FnFinish) begin
            scan_prev_q <= prv_q;
          end else begin
            if (scan_prev_q == cur_q) scan_prev_q <= prv_q;
            res_q.out_slot <= 5'({5'd0, cur_q});
          end
          state_q <= StDone;
        end
        StDone: begin
          if (!out_v_q || out_ready_i) begin
            out_q   <= res_q;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_ready_o  = state_q == StIdle;
  assign out_valid_o = out_v_q;
  assign out_rsp_o   = out_q;

endmodule

// File: test/tdmx_checker.sv
// Checker for the timed task dispatcher: watches both request/result channels,
// predicts each result from a model of the slot table, compares field by field.
// Depends on tdmx_pkg.
module tdmx_checker #(
  parameter int unsigned SLOTS   = 32,
  parameter int unsigned MUTEXES = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  tdmx_pkg::req_t  in_req_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  tdmx_pkg::rsp_t  out_rsp_i,
  output int              fail_count_o,
  output int              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tdmx_pkg::*;

  localparam int NoSlot = 'hFFFF;
  localparam logic [3:0] MutUsed = 4'((1 << MUTEXES) - 1);

  int          link_q [SLOTS];
  logic [21:0] ent_task [SLOTS];
  logic [31:0] ent_arg [SLOTS];
  logic [31:0] ent_due [SLOTS];
  int          free_head, cursor, running;
  logic [3:0]  locked;
  logic [27:0] least_wait;
  rsp_t        sched_q [$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o = sched_q.size();

  function automatic int prev_of(int k);
    int p;
    p = 0;
    for (int n = 0; n < SLOTS; n++) begin
      if (link_q[p] == k) return p;
      if (link_q[p] >= SLOTS) return NoSlot;
      p = link_q[p];
    end
    return NoSlot;
  endfunction

  function automatic void unlink_slot(int k, int p);
    link_q[p] = link_q[k];
    link_q[k] = link_q[free_head];
    link_q[free_head] = k;
    ent_task[k] = '0;
  endfunction

  function automatic bit slot_hit(int s, logic [17:0] id, logic [31:0] arg);
    if (s >= SLOTS || ent_task[s] == '0) return 0;
    return ent_task[s][17:0] == id && ent_arg[s] == arg;
  endfunction

  function automatic rsp_t schedule(req_t r);
    rsp_t o;
    logic [3:0] mm, old;
    logic [31:0] d;
    int i, j, p;
    bit found;
    o = '0;
    mm = r.mtx_bits & MutUsed;
    case (r.func)
      FnInsert: begin
        if (r.task_id == '0 || link_q[free_head] >= SLOTS) o.status = StsReject;
        else begin
          ent_task[free_head] = {mm, r.task_id};
          ent_arg[free_head] = r.task_arg;
          ent_due[free_head] = r.due_time;
          o.out_slot = 5'(free_head);
          free_head = link_q[free_head];
        end
      end
      FnDispatch: begin
        if (running != NoSlot) o.status = StsReject;
        else begin
          i = cursor;
          found = 0;
          for (int n = 0; n < SLOTS; n++) begin
            j = link_q[i];
            if (j >= SLOTS || ent_task[j] == '0) break;
            if ((ent_task[j][21:18] & locked) == '0) begin
              d = ent_due[j] - r.now;
              if (d == '0 || d[31]) begin
                running = j;
                cursor = i;
                o.out_slot = 5'(j);
                o.out_task = ent_task[j][17:0];
                o.out_arg = ent_arg[j];
                found = 1;
                break;
              end
              if (d < 32'(least_wait)) least_wait = 28'(d);
            end
            i = j;
          end
          if (!found) begin
            o.status = StsIdle;
            o.wake_delay = least_wait;
            cursor = 0;
            least_wait = MaxWait;
          end
        end
      end
      FnFinish: begin
        if (running >= SLOTS) o.status = StsNoMatch;
        else begin
          j = running;
          running = NoSlot;
          o.out_slot = 5'(j);
          d = ent_due[j] - r.now;
          if (r.keep || !d[31]) begin
            if (d[31]) begin
              ent_due[j] = r.now;
              least_wait = '0;
            end else if (d < 32'(least_wait)) least_wait = 28'(d);
            cursor = j;
          end else begin
            p = prev_of(j);
            if (p < SLOTS) begin
              unlink_slot(j, p);
              cursor = p;
            end else cursor = 0;
          end
        end
      end
      FnLock, FnUnlock: begin
        old = locked;
        locked = (r.func == FnLock ? (locked | mm) : (locked & ~mm)) & MutUsed;
        o.already_set = (locked == old);
      end
      FnDrop: begin
        if (!slot_hit(r.slot, r.task_id, r.task_arg)) o.status = StsNoMatch;
        else if (r.slot == running) o.status = StsReject;
        else begin
          p = prev_of(r.slot);
          if (p >= SLOTS) o.status = StsNoMatch;
          else begin
            unlink_slot(r.slot, p);
            if (cursor == r.slot) cursor = p;
            o.out_slot = r.slot;
          end
        end
      end
      FnRetime: begin
        if (!slot_hit(r.slot, r.task_id, r.task_arg)) o.status = StsNoMatch;
        else begin
          ent_due[r.slot] = r.due_time;
          o.out_slot = r.slot;
        end
      end
      default: o.status = StsReject;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch %s got %0h want %0h", $realtime, what, got, want);
    fails++;
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      link_q[i] = i + 1;
      ent_task[i] = '0;
      ent_arg[i] = '0;
      ent_due[i] = '0;
    end
    free_head = 1;
    cursor = 0;
    running = NoSlot;
    locked = '0;
    least_wait = MaxWait;
    fails = 0;
  end

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && in_valid_i && in_ready_i) sched_q.push_back(schedule(in_req_i));
    if (rst_ni && out_valid_i && out_ready_i) begin
      if (sched_q.size() == 0) report_mismatch("unexpected result", 0, 0);
      else begin
        want = sched_q.pop_front();
        if (out_rsp_i.status != want.status)
          report_mismatch("status", out_rsp_i.status, want.status);
        if (out_rsp_i.out_slot != want.out_slot)
          report_mismatch("out_slot", out_rsp_i.out_slot, want.out_slot);
        if (out_rsp_i.out_task != want.out_task)
          report_mismatch("out_task", out_rsp_i.out_task, want.out_task);
        if (out_rsp_i.out_arg != want.out_arg)
          report_mismatch("out_arg", out_rsp_i.out_arg, want.out_arg);
        if (out_rsp_i.wake_delay != want.wake_delay)
          report_mismatch("wake_delay", out_rsp_i.wake_delay, want.wake_delay);
        if (out_rsp_i.already_set != want.already_set)
          report_mismatch("already_set", out_rsp_i.already_set, want.already_set);
      end
    end
  end
endmodule

// File: test/tb.sv
// Top of the dispatcher testbench: clock, reset, request stimulus with bursts
// and gaps, result stalls, watchdog and verdict. Uses tdmx_pkg, the dispatcher top and tdmx_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tdmx_pkg::*;

  localparam int WatchLimit = 2000;  // far above the longest request walk plus stalls

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_rsp;
  int   fail_count, pending;
  int   idle_cycles = 0;
  bit   stall_on = 1'b0;

  // Shadow of what the tb believes is stored, so most drops/retimes hit.
  logic [17:0] known_id [32];
  logic [31:0] known_arg [32];
  logic [31:0] clock_now = 32'h0;

  always #5 clk = ~clk;

  timed_task_dispatcher_with_mutex_mask_top uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_req_i(in_req),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_rsp_o(out_rsp));

  tdmx_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_req_i(in_req),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_rsp_i(out_rsp),
    .fail_count_o(fail_count), .pending_o(pending));

  // Receiver stall: alternating windows, sometimes always ready.
  always @(posedge clk) begin
    if (!stall_on) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 2) != 0);
    if ($urandom_range(0, 60) == 0) stall_on <= ~stall_on;
  end

  // Watchdog: cycles with no request or result accepted.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Hold one request until accepted; valid stays up for the next send,
  // the caller drops it before any pause.
  task automatic send(req_t r);
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic req_t mk(logic [2:0] f);
    req_t r;
    r = '0;
    r.func = f;
    r.now = clock_now;
    return r;
  endfunction

  // Mostly well-formed traffic: inserts near the clock, dispatches and finishes,
  // drops and retimes aimed at real slots; some noise and stale arguments.
  function automatic req_t rand_req();
    req_t r;
    int k, s;
    r = '0;
    k = $urandom_range(0, 99);
    clock_now = clock_now + $urandom_range(0, 40);
    if ($urandom_range(0, 50) == 0) clock_now = $urandom;
    r.now = clock_now;
    r.task_arg = $urandom;
    r.task_id = 18'($urandom_range(1, 15));
    if ($urandom_range(0, 15) == 0) r.task_id = 18'($urandom);
    r.due_time = clock_now + 32'($urandom_range(0, 200)) - 32'd60;
    if ($urandom_range(0, 10) == 0) r.due_time = $urandom;
    r.mtx_bits = 4'($urandom);
    r.keep = 1'($urandom);
    s = $urandom_range(0, 31);
    r.slot = 5'(s);
    if (k < 25) r.func = FnInsert;
    else if (k < 50) r.func = FnDispatch;
    else if (k < 72) r.func = FnFinish;
    else if (k < 78) r.func = FnLock;
    else if (k < 84) r.func = FnUnlock;
    else if (k < 91) r.func = FnDrop;
    else if (k < 98) r.func = FnRetime;
    else r.func = 3'd7;
    if ((r.func == FnDrop || r.func == FnRetime) && $urandom_range(0, 4) != 0) begin
      r.task_id = known_id[s];
      r.task_arg = known_arg[s];
    end
    if (r.func == FnInsert) r.task_id = (k == 0) ? '0 : r.task_id;
    return r;
  endfunction

  // Learn slot contents from results so later drops and retimes can match.
  logic [17:0] last_id;
  logic [31:0] last_arg;
  logic [2:0]  fn_q [$];
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      fn_q.push_back(in_req.func);
      last_id <= in_req.task_id;
      last_arg <= in_req.task_arg;
    end
    if (rst_n && out_valid && out_ready && fn_q.size() > 0) begin
      if (fn_q.pop_front() == FnInsert && out_rsp.status == StsOk) begin
        known_id[out_rsp.out_slot] <= last_id;
        known_arg[out_rsp.out_slot] <= last_arg;
      end
    end
  end

  initial begin
    req_t r;
    int burst;
    for (int i = 0; i < 32; i++) begin
      known_id[i] = '0;
      known_arg[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-table dispatch, finish with nothing running, zero id.
    send(mk(FnDispatch));
    send(mk(FnFinish));
    r = mk(FnInsert); send(r);
    // Extremes: largest id and arg, all mutex bits, due times both ways.
    r = mk(FnInsert); r.task_id = '1; r.task_arg = '1; r.mtx_bits = '1;
    r.due_time = 32'h0; send(r);
    r = mk(FnInsert); r.task_id = 18'd1; r.due_time = 32'h7FFF_FFFF; send(r);
    r = mk(FnInsert); r.task_id = 18'd2; r.due_time = 32'h8000_0000; send(r);
    r = mk(FnLock); r.mtx_bits = 4'hF; send(r);
    send(r);                                 // bits already set
    send(mk(FnDispatch));                    // locked task skipped, overdue task found
    r = mk(FnUnlock); r.mtx_bits = 4'hF; send(r);
    send(r);
    send(mk(FnDispatch));                    // busy: rejected
    send(mk(FnDispatch));                    // busy: rejected
    r = mk(FnDrop); r.slot = 5'd1; r.task_id = '1; r.task_arg = '1; send(r);
    r = mk(FnRetime); r.slot = 5'd1; r.task_id = '1; r.task_arg = '1;
    r.due_time = 32'hFFFF_FFFF; send(r);
    r = mk(FnFinish); r.now = 32'hFFFF_FFFF; r.keep = 1'b0; send(r);
    r = mk(FnDrop); r.slot = 5'd31; send(r);  // empty slot
    r = mk(FnRetime); r.slot = 5'd2; r.task_id = 18'd1; send(r);  // id and arg match
    send(mk(3'd7));
    // Fill the table until full is reported.
    for (int i = 0; i < 31; i++) begin
      r = mk(FnInsert); r.task_id = 18'(i + 3); r.task_arg = $urandom;
      r.due_time = $urandom; send(r);
    end
    // Hold off until all results are in.
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);

    for (int n = 0; n < 1450; ) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && n < 1450; b++, n++) send(rand_req());
      if ($urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
      if (n > 700 && n < 720) begin
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
